[hw/rtl/trp_pkg.sv]
package trp_pkg;

  // Table size parameter default and field widths.
  localparam int PpnBitsDef = 20;
  localparam int LineW      = 31;
  localparam int PhysW      = 38;
  localparam int PidW       = 32;
  localparam int VpnW       = 40;
  localparam int EntryW     = PidW + VpnW;
  localparam int PageW      = PhysW - 12;
  localparam int RunW       = 56;
  localparam int TimeW      = 64;
  localparam int CfgIdxW    = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegTagWindowBase = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMarkerAddr    = 1'd1;

  localparam logic [PhysW-1:0] TagWindowBaseRst = 38'd27044872192;
  localparam logic [PhysW-1:0] MarkerAddrRst    = 38'd26910654528;
  localparam logic [PhysW-1:0] TwoGib           = 38'h0080000000;

  // Result status codes.
  localparam logic [2:0] StInvalid  = 3'd0;
  localparam logic [2:0] StTag      = 3'd1;
  localparam logic [2:0] StMapped   = 3'd2;
  localparam logic [2:0] StUnmapped = 3'd3;
  localparam logic [2:0] StMarker   = 3'd4;
  localparam logic [2:0] StBadMagic = 3'd5;
  localparam logic [2:0] StPpnRange = 3'd6;

  // Kernel record magic bytes.
  localparam logic [7:0] MagicSet     = 8'hec;
  localparam logic [7:0] MagicFree0   = 8'hfc;
  localparam logic [7:0] MagicFree1   = 8'h22;
  localparam logic [7:0] MagicFree2   = 8'h33;
  localparam logic [7:0] MagicMissing = 8'h24;

  // Tag slots inside a 1 MiB tag block.
  localparam logic [7:0] SlotSet  = 8'd0;
  localparam logic [7:0] SlotFree = 8'd1;
  localparam logic [7:0] SlotEnd  = 8'd3;

  typedef struct packed {
    logic [47:0] trace_word;
    logic [7:0]  kt_magic;
    logic [31:0] kt_pid;
    logic [63:0] kt_value;
    logic        kt_is_end_marker;
  } trp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        kt_taken;
    logic        is_write;
    logic [37:0] phys_addr;
    logic [63:0] timestamp;
    logic [31:0] proc_id;
    logic [51:0] virt_addr;
  } trp_out_t;

  typedef struct packed {
    logic clear_we;
    logic capture;
    logic commit;
  } trp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } trp_sts_t;

endpackage

[hw/rtl/trp_ctrl.sv]
module trp_ctrl import trp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  trp_sts_t sts_i,
  output trp_cmd_t cmd_o
);

  localparam logic [1:0] StateClear = 2'd0;
  localparam logic [1:0] StateIdle  = 2'd1;
  localparam logic [1:0] StateRun   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StateClear: begin
        cmd_o.clear_we = 1'b1;
        if (sts_i.clear_last) begin
          state_d = StateIdle;
        end
      end
      StateIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StateRun;
        end
      end
      StateRun: begin
        // The result waits here until the output register can take it.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StateIdle;
        end
      end
      default: begin
        state_d = StateClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/trp_datapath.sv]
module trp_datapath import trp_pkg::*; #(
  parameter int PpnBits = PpnBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trp_cmd_t           cmd_i,
  output trp_sts_t           sts_o,
  input  trp_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output trp_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PhysW-1:0]   cfg_data_i
);

  localparam int Depth = 1 << PpnBits;

  function automatic logic [PhysW-1:0] remap(input logic [LineW-1:0] line);
    logic [PhysW-1:0] raw;
    raw = {1'b0, line, 6'b0};
    if (raw[PhysW-2:31] != '0) begin
      remap = raw + TwoGib;
    end else begin
      remap = raw;
    end
  endfunction

  logic [EntryW-1:0]  mem [Depth];
  logic [EntryW-1:0]  rd_q;
  trp_in_t            in_q;
  logic [TimeW-1:0]   time_q, time_d;
  logic [RunW-1:0]    run_q, run_d;
  logic               ended_q, ended_d;
  logic [PhysW-1:0]   base_q, marker_q;
  trp_out_t           out_q, out_d;
  logic               out_valid_q;
  logic [PpnBits-1:0] clr_addr_q;

  logic [PhysW-1:0]   pa_in, pa;
  logic [PageW-1:0]   page_in, page;
  logic [7:0]         delta8;
  logic               invalid;
  logic [PhysW:0]     diff;
  logic               in_win;
  logic [7:0]         slot;
  logic               half;
  logic [23:0]        ppn;
  logic [VpnW-1:0]    vpn;
  logic               ppn_oob, page_oob;
  logic [TimeW-1:0]   time_sum;
  logic               free_magic;
  logic               mem_we;
  logic [PpnBits-1:0] mem_waddr;
  logic [EntryW-1:0]  mem_wdata;

  assign pa_in   = remap(in_data_i.trace_word[LineW-1:0]);
  assign page_in = pa_in[PhysW-1:12];

  assign pa       = remap(in_q.trace_word[LineW-1:0]);
  assign page     = pa[PhysW-1:12];
  assign delta8   = in_q.trace_word[39:32];
  assign invalid  = (in_q.trace_word[LineW-1:0] == '0) && (delta8 == '0);
  // Pending invalid words count 256 each, so they fill the bits above the delta.
  assign time_sum = time_q + {run_q, delta8};

  // Inside the 64 MiB window when the difference is non-negative and below 2^26.
  assign diff   = {1'b0, pa} - {1'b0, base_q};
  assign in_win = !ended_q && !diff[PhysW] && (diff[PhysW-1:26] == '0);
  assign slot   = diff[19:12];
  assign half   = diff[11];

  assign ppn      = in_q.kt_value[23:0];
  assign vpn      = in_q.kt_value[63:24];
  assign ppn_oob  = (ppn >> PpnBits) != '0;
  assign page_oob = (page >> PpnBits) != '0;
  assign free_magic = (in_q.kt_magic == MagicFree0) || (in_q.kt_magic == MagicFree1) ||
                      (in_q.kt_magic == MagicFree2);

  always_comb begin
    out_d           = '0;
    time_d          = time_q;
    run_d           = run_q;
    ended_d         = ended_q;
    mem_we          = 1'b0;
    mem_waddr       = ppn[PpnBits-1:0];
    mem_wdata       = '0;
    if (invalid) begin
      out_d.status = StInvalid;
      run_d        = run_q + RunW'(1);
    end else begin
      run_d           = '0;
      time_d          = time_sum;
      out_d.is_write  = in_q.trace_word[31];
      out_d.phys_addr = pa;
      out_d.timestamp = time_sum;
      priority if (in_win) begin
        out_d.status = StTag;
        // The upper half of each 4 KiB slot carries no command.
        if (!half) begin
          priority if (slot == SlotSet) begin
            priority if (in_q.kt_magic == MagicMissing) begin
              out_d.status = StTag;
            end else if (in_q.kt_magic != MagicSet) begin
              out_d.status = StBadMagic;
            end else begin
              out_d.kt_taken = 1'b1;
              if (ppn_oob) begin
                out_d.status = StPpnRange;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {in_q.kt_pid, vpn};
              end
            end
          end else if (slot == SlotFree) begin
            if (free_magic) begin
              out_d.kt_taken = 1'b1;
              if (ppn_oob) begin
                out_d.status = StPpnRange;
              end else begin
                mem_we = 1'b1;
              end
            end
          end else if (slot == SlotEnd) begin
            out_d.kt_taken = in_q.kt_is_end_marker;
            ended_d        = 1'b1;
          end else begin
            out_d.status = StTag;
          end
        end
      end else if (pa == marker_q) begin
        out_d.status = StMarker;
      end else if (!page_oob && (rd_q != '0)) begin
        out_d.status    = StMapped;
        out_d.proc_id   = rd_q[EntryW-1:VpnW];
        out_d.virt_addr = {rd_q[VpnW-1:0], pa[11:0]};
      end else begin
        out_d.status = StUnmapped;
      end
    end
    if (cmd_i.clear_we) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (!cmd_i.commit) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.capture) begin
      rd_q <= mem[page_in[PpnBits-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      run_q       <= '0;
      ended_q     <= 1'b0;
      base_q      <= TagWindowBaseRst;
      marker_q    <= MarkerAddrRst;
      out_valid_q <= 1'b0;
      clr_addr_q  <= '0;
    end else begin
      if (cmd_i.commit) begin
        time_q  <= time_d;
        run_q   <= run_d;
        ended_q <= ended_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegTagWindowBase: base_q   <= cfg_data_i;
          RegMarkerAddr:    marker_q <= cfg_data_i;
          default:          base_q   <= base_q;
        endcase
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear_we) begin
        clr_addr_q <= clr_addr_q + PpnBits'(1);
      end
    end
  end

  assign sts_o.clear_last = &clr_addr_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule

[hw/rtl/trace_reverse_page_translator.sv]
// Translates raw memory-trace words into physical and virtual accesses. Each word
// is first captured while the page table, a synchronous memory of 2^PPN_BITS
// entries, is read; then, once the output register can take the result, the word
// is resolved and, for a kernel sync tag, the table is written back. The result
// goes to an output register, so the next word is taken while a result still waits
// there. After reset the table is cleared one entry per cycle, and no word is
// accepted until that pass ends; configuration writes are accepted at any time.
module trace_reverse_page_translator import trp_pkg::*; #(
  parameter int PPN_BITS = PpnBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  trp_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output trp_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PhysW-1:0]   cfg_data_i
);

  trp_cmd_t cmd;
  trp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  trp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trp_datapath #(
    .PpnBits (PPN_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

[sim/trp_result_checker.sv]
`timescale 1ns / 1ps

module trp_result_checker import trp_pkg::*; #(
  parameter int PPN_BITS = PpnBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  trp_in_t            in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  trp_out_t           out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PhysW-1:0]   cfg_data_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  localparam logic [63:0] TableDepth = 64'd1 << PPN_BITS;
  localparam logic [63:0] TwoGibL    = 64'h8000_0000;
  localparam logic [63:0] WindowSize = 64'h400_0000;

  // Only pages that were ever set are held; a missing entry reads as zero.
  logic [PidW-1:0] pid_by_ppn [longint unsigned];
  logic [VpnW-1:0] vpn_by_ppn [longint unsigned];
  logic [TimeW-1:0] time_total;
  logic [RunW-1:0]  invalid_run;
  logic             tags_ended;
  logic [PhysW-1:0] window_base;
  logic [PhysW-1:0] marker_addr;
  trp_out_t         expected_results[$];
  int unsigned      err_count;

  task automatic report_mismatch(string msg);
    $display("%0t trp_result_checker: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  // Works out the result of one trace word and advances the translation state.
  function automatic trp_out_t translate_word(trp_in_t w);
    trp_out_t        r;
    logic [63:0]     pa;
    logic [63:0]     off;
    logic [63:0]     ppn;
    logic [63:0]     page;
    logic [7:0]      slot;
    logic [PidW-1:0] pid;
    logic [VpnW-1:0] vpn;
    r = '0;
    pa = 64'(w.trace_word[30:0]) << 6;
    if (pa == 64'd0 && w.trace_word[39:32] == 8'd0) begin
      invalid_run = invalid_run + 1'b1;
      return r;
    end
    // Each invalid word in a row stands for 256 time units.
    time_total = time_total + 64'(w.trace_word[39:32]) + (64'(invalid_run) << 8);
    invalid_run = '0;
    if (pa >= TwoGibL) begin
      pa = pa + TwoGibL;
    end
    r.is_write = w.trace_word[31];
    r.phys_addr = pa[PhysW-1:0];
    r.timestamp = time_total;

    if (!tags_ended && pa >= 64'(window_base) && pa < 64'(window_base) + WindowSize) begin
      r.status = StTag;
      off = pa - 64'(window_base);
      slot = off[19:12];
      ppn = 64'(w.kt_value[23:0]);
      // The upper half of each 4 KiB slot carries no command.
      if (!off[11]) begin
        case (slot)
          SlotSet: begin
            if (w.kt_magic == MagicSet) begin
              r.kt_taken = 1'b1;
              if (ppn >= TableDepth) begin
                r.status = StPpnRange;
              end else begin
                pid_by_ppn[ppn] = w.kt_pid;
                vpn_by_ppn[ppn] = w.kt_value[63:24];
              end
            end else if (w.kt_magic != MagicMissing) begin
              r.status = StBadMagic;
            end
          end
          SlotFree: begin
            if (w.kt_magic == MagicFree0 || w.kt_magic == MagicFree1 ||
                w.kt_magic == MagicFree2) begin
              r.kt_taken = 1'b1;
              if (ppn >= TableDepth) begin
                r.status = StPpnRange;
              end else begin
                pid_by_ppn.delete(ppn);
                vpn_by_ppn.delete(ppn);
              end
            end
          end
          SlotEnd: begin
            r.kt_taken = w.kt_is_end_marker;
            tags_ended = 1'b1;
          end
          default: ;
        endcase
      end
      return r;
    end

    if (pa == 64'(marker_addr)) begin
      r.status = StMarker;
      return r;
    end

    page = pa >> 12;
    pid = '0;
    vpn = '0;
    if (page < TableDepth && pid_by_ppn.exists(page)) begin
      pid = pid_by_ppn[page];
      vpn = vpn_by_ppn[page];
    end
    if (pid != '0 || vpn != '0) begin
      r.status = StMapped;
      r.proc_id = pid;
      r.virt_addr = {vpn, pa[11:0]};
    end else begin
      r.status = StUnmapped;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    trp_out_t want;
    if (!rst_ni) begin
      pid_by_ppn.delete();
      vpn_by_ppn.delete();
      expected_results.delete();
      time_total = '0;
      invalid_run = '0;
      tags_ended = 1'b0;
      window_base = TagWindowBaseRst;
      marker_addr = MarkerAddrRst;
      err_count = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegTagWindowBase: window_base = cfg_data_i;
          RegMarkerAddr:    marker_addr = cfg_data_i;
          default: ;
        endcase
      end
      // A result leaving at this edge can never belong to a word taken at this edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected, status %0d",
                                    out_data_i.status));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(out_data_i.status), 64'(want.status));
          check_field("kt_taken", 64'(out_data_i.kt_taken), 64'(want.kt_taken));
          check_field("is_write", 64'(out_data_i.is_write), 64'(want.is_write));
          check_field("phys_addr", 64'(out_data_i.phys_addr), 64'(want.phys_addr));
          check_field("timestamp", out_data_i.timestamp, want.timestamp);
          check_field("proc_id", 64'(out_data_i.proc_id), 64'(want.proc_id));
          check_field("virt_addr", 64'(out_data_i.virt_addr), 64'(want.virt_addr));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(translate_word(in_data_i));
      end
      errors_o <= err_count;
      pending_o <= expected_results.size();
    end
  end

endmodule

[sim/tb_trace_reverse_page_translator.sv]
`timescale 1ns / 1ps

module tb_trace_reverse_page_translator;
  import trp_pkg::*;

  localparam int          PpnBits    = PpnBitsDef;
  // The table clear after reset goes one entry per cycle with nothing accepted.
  localparam int unsigned IdleLimit  = 4 * (1 << PpnBits) + 50_000;
  localparam logic [63:0] TwoGibL    = 64'h8000_0000;
  localparam logic [63:0] WindowSize = 64'h400_0000;
  localparam logic [63:0] PhysTop    = 64'h20_7FFF_FFC0;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  trp_in_t            in_data;
  logic               out_valid;
  logic               out_ready;
  trp_out_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [PhysW-1:0]   cfg_data;
  int unsigned        mismatches;
  int unsigned        outstanding;
  int unsigned        idle_cycles = 0;
  int unsigned        results_seen = 0;
  logic [63:0]        win_base;
  logic [63:0]        marker_pa;
  logic [23:0]        mapped_ppns[$];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  trace_reverse_page_translator #(
    .PPN_BITS(PpnBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  trp_result_checker #(
    .PPN_BITS(PpnBits)
  ) checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (mismatches),
    .pending_o  (outstanding)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_trace_reverse_page_translator: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
    end
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned gap_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [30:0] line_of(logic [63:0] pa);
    if (pa >= TwoGibL) return 31'((pa - TwoGibL) >> 6);
    return 31'(pa >> 6);
  endfunction

  function automatic logic [63:0] phys_of_line(logic [30:0] line);
    logic [63:0] pa;
    pa = 64'(line) << 6;
    if (pa >= TwoGibL) pa = pa + TwoGibL;
    return pa;
  endfunction

  // An access to a byte address with a random delta, direction and pending record.
  function automatic trp_in_t access_word(logic [63:0] pa);
    trp_in_t w;
    w.trace_word = {8'($urandom), 8'($urandom), 1'($urandom), line_of(pa)};
    w.kt_magic = 8'($urandom);
    w.kt_pid = $urandom;
    w.kt_value = {$urandom, $urandom};
    w.kt_is_end_marker = 1'($urandom);
    return w;
  endfunction

  function automatic trp_in_t tag_word(logic [7:0] slot, logic half, logic [7:0] magic,
                                       logic [23:0] ppn);
    trp_in_t     w;
    logic [63:0] pa;
    pa = win_base + (64'($urandom_range(0, 63)) << 20) + (64'(slot) << 12) +
         (64'(half) << 11) + (64'($urandom_range(0, 31)) << 6);
    w = access_word(pa);
    w.kt_magic = magic;
    w.kt_value[23:0] = ppn;
    return w;
  endfunction

  function automatic logic [7:0] free_magic();
    case ($urandom_range(0, 2))
      0:       return MagicFree0;
      1:       return MagicFree1;
      default: return MagicFree2;
    endcase
  endfunction

  // Mostly set, look up and free pages; the rest is noise and broken tags.
  function automatic trp_in_t random_word();
    trp_in_t     w;
    int unsigned pick;
    logic [23:0] ppn;
    logic [7:0]  slot;
    pick = $urandom_range(0, 99);
    if (mapped_ppns.size() != 0) begin
      ppn = mapped_ppns[$urandom_range(0, mapped_ppns.size() - 1)];
    end else begin
      ppn = 24'($urandom_range(0, 255));
    end
    if (pick < 25) begin
      if ($urandom_range(0, 3) == 0) ppn = 24'($urandom_range(0, (1 << 19) - 1));
      else ppn = 24'($urandom_range(0, 255));
      // With the window at zero, a lookup of such a page would hit the end slot.
      if (ppn[7:0] == SlotEnd) ppn[0] = 1'b0;
      w = tag_word(SlotSet, 1'b0, MagicSet, ppn);
      mapped_ppns.push_back(ppn);
      if (mapped_ppns.size() > 48) void'(mapped_ppns.pop_front());
    end else if (pick < 57) begin
      w = access_word((64'(ppn) << 12) | (64'($urandom_range(0, 63)) << 6));
    end else if (pick < 65) begin
      w = tag_word(SlotFree, 1'b0, free_magic(), ppn);
    end else if (pick < 72) begin
      w = access_word(64'd0);
      w.trace_word[39:32] = 8'd0;
    end else if (pick < 76) begin
      w = access_word(marker_pa);
    end else if (pick < 88) begin
      w = access_word(64'd0);
      w.trace_word = {16'($urandom), $urandom};
    end else begin
      slot = 8'($urandom);
      if (slot == SlotEnd) slot = SlotFree;
      w = tag_word(slot, 1'($urandom), 8'($urandom), 24'($urandom));
    end
    return w;
  endfunction

  task automatic send_word(trp_in_t w);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PhysW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegTagWindowBase: win_base = 64'(val);
      RegMarkerAddr:    marker_pa = 64'(val);
      default: ;
    endcase
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : sink
    int unsigned hold;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        hold = 300;
      end else begin
        hold = gap_cycles();
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : stimulus
    trp_in_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    win_base = 64'(TagWindowBaseRst);
    marker_pa = 64'(MarkerAddrRst);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(RegTagWindowBase, TagWindowBaseRst);
    write_reg(RegMarkerAddr, MarkerAddrRst);
    cfg_valid <= 1'b0;

    // A run of invalid words, with the write bit and the unused top bits set.
    w = access_word(64'd0);
    w.trace_word[47:31] = 17'h1FE01;
    send_word(w);
    send_word(w);
    w = access_word(64'd64);
    w.trace_word[39:32] = 8'd0;
    send_word(w);
    w = access_word(PhysTop);
    w.trace_word[39:31] = 9'h1FF;
    send_word(w);
    // Address zero with a nonzero delta is a real access.
    w = access_word(64'd0);
    w.trace_word[39:32] = 8'd1;
    send_word(w);
    send_word(access_word(TwoGibL - 64'd64));
    send_word(access_word(TwoGibL << 1));

    w = tag_word(SlotSet, 1'b0, MagicSet, 24'd5);
    w.kt_pid = '1;
    w.kt_value[63:24] = '1;
    send_word(w);
    send_word(access_word(64'h5FC0));
    send_word(tag_word(SlotSet, 1'b0, MagicMissing, 24'd6));
    send_word(tag_word(SlotSet, 1'b0, 8'h00, 24'd6));
    send_word(tag_word(SlotSet, 1'b0, MagicSet, 24'h10_0000));
    send_word(tag_word(SlotSet, 1'b0, MagicSet, 24'hFF_FFFF));
    send_word(tag_word(SlotSet, 1'b0, MagicSet, 24'h0F_FFFF));
    send_word(tag_word(SlotSet, 1'b1, MagicSet, 24'd7));
    send_word(tag_word(SlotFree, 1'b0, MagicFree0, 24'd5));
    send_word(access_word(64'h5040));
    send_word(tag_word(SlotFree, 1'b0, MagicFree1, 24'hFF_FFFF));
    send_word(tag_word(SlotFree, 1'b0, MagicFree2, 24'd9));
    send_word(tag_word(SlotFree, 1'b0, MagicSet, 24'd5));
    send_word(tag_word(SlotFree, 1'b0, MagicMissing, 24'd5));
    send_word(tag_word(8'd2, 1'b0, MagicSet, 24'd5));
    send_word(access_word(marker_pa));
    send_word(access_word(win_base + WindowSize - 64'd64));
    send_word(access_word(win_base - 64'd64));

    repeat (500) send_word(random_word());
    drain_results();

    // Window at the bottom of memory, over the mapped pages, with the marker inside it.
    write_reg(RegTagWindowBase, '0);
    write_reg(RegMarkerAddr, '0);
    cfg_valid <= 1'b0;
    repeat (150) send_word(random_word());
    drain_results();

    // Window out of reach, so every word that is not invalid is a lookup or a marker.
    write_reg(RegTagWindowBase, '1);
    write_reg(RegMarkerAddr, PhysW'(phys_of_line(31'($urandom))));
    cfg_valid <= 1'b0;
    repeat (150) send_word(random_word());
    drain_results();

    write_reg(RegTagWindowBase,
              PhysW'(phys_of_line(31'($urandom_range(32'h0200_0000, 32'h7FE0_0000)))));
    write_reg(RegMarkerAddr, '1);
    cfg_valid <= 1'b0;
    repeat (100) send_word(random_word());
    // After the end tag the window no longer holds tags.
    send_word(tag_word(SlotEnd, 1'b0, 8'($urandom), 24'($urandom)));
    send_word(tag_word(SlotSet, 1'b0, MagicSet, 24'd5));
    repeat (250) send_word(random_word());
    drain_results();
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_trace_reverse_page_translator: clean");
    end else begin
      $display("tb_trace_reverse_page_translator: errors");
    end
    $finish;
  end

endmodule
